[src/somhm_pkg.sv]
// Shared constants, types and command codes for the socket owner hash map.
package somhm_pkg;

  localparam int KEY_W      = 32;
  localparam int PID_W      = 23;
  localparam int NAME_W     = 64;
  localparam int SHIFT_W    = 4;
  localparam int COUNT_W    = 11;
  localparam int EPOCH_W    = 4;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam int BUCKETS      = 1024;
  localparam int BUCKET_W     = $clog2(BUCKETS);
  localparam int ENTRIES_DEF  = 1024;

  localparam logic [KEY_W-1:0]   KNUTH_MULT     = 32'd2654435761;
  localparam logic [SHIFT_W-1:0] HASH_SHIFT_RST = 4'd10;

  localparam int ITEM_W      = KEY_W + PID_W + 2 * NAME_W;
  localparam int IN_DATA_W   = ((ITEM_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = PID_W + 2 * NAME_W + COUNT_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // key sits in the low bits, matching the request layout
  typedef struct packed {
    logic [NAME_W-1:0] name_high;
    logic [NAME_W-1:0] name_low;
    logic [PID_W-1:0]  owner_pid;
    logic [KEY_W-1:0]  inode_key;
  } entry_data_t;

endpackage

[src/somhm_hash.sv]
// Multiplicative bucket hash: registered 32x32 product, then shift and wrap.
module somhm_hash import somhm_pkg::*; (
  input  logic                clk,
  input  logic [KEY_W-1:0]    key,
  input  logic [SHIFT_W-1:0]  hash_shift,
  output logic [BUCKET_W-1:0] bucket
);

  logic [KEY_W-1:0]   prod_r;
  logic [5:0]         shift_amt;
  logic [2*KEY_W-1:0] prod_ext;

  always_ff @(posedge clk) begin
    prod_r <= key * KNUTH_MULT;
  end

  // a shift of zero moves the whole product out, so every key lands in bucket 0
  assign shift_amt = 6'd32 - {2'b00, hash_shift};
  assign prod_ext  = {{KEY_W{1'b0}}, prod_r} >> shift_amt;
  assign bucket    = prod_ext[BUCKET_W-1:0];

endmodule

[src/socket_owner_hash_map.sv]
// Top level: chained hash table from socket inode to owner pid and name.
//
//  channel | dir | handshake              | contents
//  in_*    | in  | in_tvalid / in_tready   | tuser command, tdata key, pid, name
//  out_*   | out | out_tvalid / out_tready | tuser found, status; tdata pid, name, count
//  cfg_*   | in  | cfg_wr_en               | hash_shift
//
// Lookup and insert walk the chain, reading one entry per cycle from the entry
// memory port. Clear starts a new epoch, except every 15th, which sweeps the
// bucket memory. After reset the same sweep runs with in_tready low.
// A waiting result does not block the next request; a stalled result blocks
// only the completion of the following one.
module socket_owner_hash_map import somhm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [SHIFT_W-1:0]    cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // inode_key, owner_pid_in, name_low_in, name_high_in
  input  logic [CMD_W-1:0]      in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // owner_pid, owner_name_low, owner_name_high, entry_count
  output logic [STATUS_W-1:0]   out_tuser   // found, status
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LINK_W = IDX_W + 1;
  localparam int HEAD_W = EPOCH_W + IDX_W;

  localparam logic [EPOCH_W-1:0]   EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0]   EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0]   EPOCH_LAST  = '1;
  localparam logic [CNT_W-1:0]     CNT_FULL    = CNT_W'(ENTRIES);
  localparam logic [BUCKET_W-1:0]  SWEEP_LAST  = BUCKET_W'(BUCKETS - 1);
  localparam logic [OUT_PAD_W-1:0] OUT_PAD     = '0;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MUL, S_BKT, S_HEAD, S_WALK, S_RESOLVE, S_LINK, S_DONE
  } state_t;

  // memories
  logic [HEAD_W-1:0] bkt_mem [BUCKETS];
  entry_data_t       dat_mem [ENTRIES];
  logic [LINK_W-1:0] lnk_mem [ENTRIES];

  logic [HEAD_W-1:0] bkt_rdata_r;
  entry_data_t       dat_rdata_r;
  logic [LINK_W-1:0] lnk_rdata_r;

  logic                bkt_we, bkt_re, dat_we, lnk_we, ent_re;
  logic [BUCKET_W-1:0] bkt_waddr, bkt_raddr;
  logic [HEAD_W-1:0]   bkt_wdata;
  logic [IDX_W-1:0]    lnk_waddr, ent_raddr;
  logic [LINK_W-1:0]   lnk_wdata;

  // control
  state_t              state_r, state_nxt;
  logic [SHIFT_W-1:0]  shift_r;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BUCKET_W-1:0] sweep_r, sweep_nxt;
  logic                clr_pend_r, clr_pend_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // payload
  cmd_t                cmd_r, cmd_nxt;
  entry_data_t         item_r, item_nxt;
  logic [BUCKET_W-1:0] bkt_r, bkt_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic                tail_vld_r, tail_vld_nxt;
  logic                found_r, found_nxt;
  logic                status_r, status_nxt;
  logic [PID_W-1:0]    res_pid_r, res_pid_nxt;
  logic [NAME_W-1:0]   res_nlo_r, res_nlo_nxt;
  logic [NAME_W-1:0]   res_nhi_r, res_nhi_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_status_r, out_status_nxt;
  logic [PID_W-1:0]    out_pid_r, out_pid_nxt;
  logic [NAME_W-1:0]   out_nlo_r, out_nlo_nxt;
  logic [NAME_W-1:0]   out_nhi_r, out_nhi_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [BUCKET_W-1:0] bucket;
  logic [IDX_W-1:0]    new_idx;
  logic                key_hit;

  somhm_hash u_hash (
    .clk        (clk),
    .key        (item_r.inode_key),
    .hash_shift (shift_r),
    .bucket     (bucket)
  );

  assign new_idx = count_r[IDX_W-1:0];
  assign key_hit = (item_r.inode_key != '0) && (dat_rdata_r.inode_key == item_r.inode_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= HASH_SHIFT_RST;
    end else if (cfg_wr_en) begin
      shift_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rdata_r <= bkt_mem[bkt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dat_we) begin
      dat_mem[new_idx] <= item_r;
    end
    if (ent_re) begin
      dat_rdata_r <= dat_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (ent_re) begin
      lnk_rdata_r <= lnk_mem[ent_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    count_nxt      = count_r;
    sweep_nxt      = sweep_r;
    clr_pend_nxt   = clr_pend_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd_nxt        = cmd_r;
    item_nxt       = item_r;
    bkt_nxt        = bkt_r;
    cur_nxt        = cur_r;
    tail_nxt       = tail_r;
    tail_vld_nxt   = tail_vld_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    res_pid_nxt    = res_pid_r;
    res_nlo_nxt    = res_nlo_r;
    res_nhi_nxt    = res_nhi_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_pid_nxt    = out_pid_r;
    out_nlo_nxt    = out_nlo_r;
    out_nhi_nxt    = out_nhi_r;
    out_count_nxt  = out_count_r;
    bkt_we         = 1'b0;
    bkt_waddr      = bkt_r;
    bkt_wdata      = {epoch_r, new_idx};
    bkt_re         = 1'b0;
    bkt_raddr      = bucket;
    dat_we         = 1'b0;
    lnk_we         = 1'b0;
    lnk_waddr      = new_idx;
    lnk_wdata      = '0;
    ent_re         = 1'b0;
    ent_raddr      = cur_r;

    unique case (state_r)
      S_INIT: begin
        // sweep every bucket to a tag no live epoch uses
        bkt_we    = 1'b1;
        bkt_waddr = sweep_r;
        bkt_wdata = {EPOCH_NONE, {IDX_W{1'b0}}};
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt    = '0;
          epoch_nxt    = EPOCH_FIRST;
          count_nxt    = '0;
          clr_pend_nxt = 1'b0;
          state_nxt    = clr_pend_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = cmd_t'(in_tuser);
          item_nxt     = entry_data_t'(in_tdata[ITEM_W-1:0]);
          found_nxt    = 1'b0;
          status_nxt   = 1'b0;
          tail_vld_nxt = 1'b0;
          res_pid_nxt  = '0;
          res_nlo_nxt  = '0;
          res_nhi_nxt  = '0;
          case (cmd_t'(in_tuser)) inside
            CMD_LOOKUP, CMD_INSERT: state_nxt = S_MUL;
            CMD_CLEAR: begin
              if (epoch_r == EPOCH_LAST) begin
                clr_pend_nxt = 1'b1;
                state_nxt    = S_INIT;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
                count_nxt = '0;
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_BKT;
      end
      S_BKT: begin
        bkt_re    = 1'b1;
        bkt_nxt   = bucket;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (bkt_rdata_r[HEAD_W-1 -: EPOCH_W] == epoch_r) begin
          ent_re    = 1'b1;
          ent_raddr = bkt_rdata_r[IDX_W-1:0];
          cur_nxt   = bkt_rdata_r[IDX_W-1:0];
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_WALK: begin
        if (key_hit) begin
          found_nxt   = 1'b1;
          res_pid_nxt = dat_rdata_r.owner_pid;
          res_nlo_nxt = dat_rdata_r.name_low;
          res_nhi_nxt = dat_rdata_r.name_high;
          state_nxt   = S_RESOLVE;
        end else if (lnk_rdata_r[IDX_W]) begin
          ent_re    = 1'b1;
          ent_raddr = lnk_rdata_r[IDX_W-1:0];
          cur_nxt   = lnk_rdata_r[IDX_W-1:0];
        end else begin
          tail_vld_nxt = 1'b1;
          tail_nxt     = cur_r;
          state_nxt    = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_INSERT && !found_r) begin
          if (count_r == CNT_FULL) begin
            status_nxt = 1'b1;
          end else begin
            // new entry body plus a terminated link
            dat_we    = 1'b1;
            lnk_we    = 1'b1;
            lnk_waddr = new_idx;
            lnk_wdata = '0;
            state_nxt = S_LINK;
          end
        end
      end
      S_LINK: begin
        if (tail_vld_r) begin
          lnk_we    = 1'b1;
          lnk_waddr = tail_r;
          lnk_wdata = {1'b1, new_idx};
        end else begin
          bkt_we    = 1'b1;
          bkt_waddr = bkt_r;
          bkt_wdata = {epoch_r, new_idx};
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = found_r;
          out_status_nxt = status_r;
          out_pid_nxt    = res_pid_r;
          out_nlo_nxt    = res_nlo_r;
          out_nhi_nxt    = res_nhi_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      epoch_r      <= EPOCH_FIRST;
      count_r      <= '0;
      sweep_r      <= '0;
      clr_pend_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      count_r      <= count_nxt;
      sweep_r      <= sweep_nxt;
      clr_pend_r   <= clr_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r        <= cmd_nxt;
    item_r       <= item_nxt;
    bkt_r        <= bkt_nxt;
    cur_r        <= cur_nxt;
    tail_r       <= tail_nxt;
    tail_vld_r   <= tail_vld_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    res_pid_r    <= res_pid_nxt;
    res_nlo_r    <= res_nlo_nxt;
    res_nhi_r    <= res_nhi_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_pid_r    <= out_pid_nxt;
    out_nlo_r    <= out_nlo_nxt;
    out_nhi_r    <= out_nhi_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {OUT_PAD, out_count_r, out_nhi_r, out_nlo_r, out_pid_r};
  assign out_tuser  = {out_status_r, out_found_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count beyond pool size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(bkt_we || dat_we || lnk_we))
    else $error("memory write while waiting for a request");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == CNT_W'($past(count_r) + 1'b1)) || (count_r == '0))
    else $error("entry count moved by more than one");
`endif

endmodule

[tb/socket_owner_hash_map_test.sv]
// Stimulus, prediction and checking for the socket owner hash map.
`timescale 1ns / 1ps

module socket_owner_hash_map_test;
  import somhm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_ERR_LINES = 40;
  localparam int RECENT_KEYS = 16;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [PID_W-1:0]  pid;
    logic [NAME_W-1:0] name_lo;
    logic [NAME_W-1:0] name_hi;
  } sock_req_t;

  typedef struct packed {
    logic               found;
    logic [PID_W-1:0]   pid;
    logic [NAME_W-1:0]  name_lo;
    logic [NAME_W-1:0]  name_hi;
    logic               status;
    logic [COUNT_W-1:0] count;
  } owner_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [SHIFT_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  socket_owner_hash_map u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // inode_key, owner_pid_in, name_low_in, name_high_in
    .in_tuser   (in_tuser),   // command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // owner_pid, owner_name_low, owner_name_high, entry_count
    .out_tuser  (out_tuser)   // found, status
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the table
  logic [SHIFT_W-1:0] shift_now = HASH_SHIFT_RST;
  bit                 slot_used [BUCKETS];
  int unsigned        slot_head [BUCKETS];
  logic [KEY_W-1:0]   pool_key  [ENTRIES_DEF];
  logic [PID_W-1:0]   pool_pid  [ENTRIES_DEF];
  logic [NAME_W-1:0]  pool_nlo  [ENTRIES_DEF];
  logic [NAME_W-1:0]  pool_nhi  [ENTRIES_DEF];
  bit                 pool_link_ok [ENTRIES_DEF];
  int unsigned        pool_link [ENTRIES_DEF];
  int unsigned        pool_fill = 0;

  sock_req_t    sock_req_q [$];
  owner_reply_t owner_reply_q [$];
  logic [KEY_W-1:0] recent_keys [$];

  sock_req_t sending;
  int  send_gap = 0;
  int  recv_hold = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;
  int  mismatch_count = 0;
  int  cycle_count = 0;

  function automatic int unsigned knuth_bucket(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    logic [63:0]      wide;
    prod = key * KNUTH_MULT;
    // shift of zero moves the whole product out: everything lands in bucket 0
    wide = {32'd0, prod} >> (32 - int'(shift_now));
    return int'(wide % BUCKETS);
  endfunction

  // Returns the matching entry or -1; tail is the last entry visited or -1.
  function automatic int find_owner(input logic [KEY_W-1:0] key, output int tail);
    int unsigned b;
    int cur;
    int steps;
    tail = -1;
    b = knuth_bucket(key);
    if (!slot_used[b]) return -1;
    cur = slot_head[b];
    for (steps = 0; steps < ENTRIES_DEF; steps++) begin
      tail = cur;
      if (key != '0 && pool_key[cur] == key) return cur;
      if (!pool_link_ok[cur]) break;
      cur = pool_link[cur];
    end
    return -1;
  endfunction

  function automatic void predict_owner_reply(input sock_req_t r);
    owner_reply_t e;
    int hit;
    int tail;
    int unsigned slot;
    e = '0;
    if (r.cmd == CMD_LOOKUP || r.cmd == CMD_INSERT) begin
      hit = find_owner(r.key, tail);
      if (hit >= 0) begin
        e.found   = 1'b1;
        e.pid     = pool_pid[hit];
        e.name_lo = pool_nlo[hit];
        e.name_hi = pool_nhi[hit];
      end else if (r.cmd == CMD_INSERT) begin
        if (pool_fill >= ENTRIES_DEF) begin
          e.status = 1'b1;
        end else begin
          pool_key[pool_fill]     = r.key;
          pool_pid[pool_fill]     = r.pid;
          pool_nlo[pool_fill]     = r.name_lo;
          pool_nhi[pool_fill]     = r.name_hi;
          pool_link_ok[pool_fill] = 1'b0;
          if (tail < 0) begin
            slot = knuth_bucket(r.key);
            slot_head[slot] = pool_fill;
            slot_used[slot] = 1'b1;
          end else begin
            pool_link[tail]    = pool_fill;
            pool_link_ok[tail] = 1'b1;
          end
          pool_fill++;
        end
      end
    end else if (r.cmd == CMD_CLEAR) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      pool_fill = 0;
    end
    e.count = pool_fill[COUNT_W-1:0];
    owner_reply_q.push_back(e);
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < MAX_ERR_LINES) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic sock_req_t make_request(input logic [CMD_W-1:0] cmd,
                                             input logic [KEY_W-1:0] key);
    sock_req_t r;
    r.cmd     = cmd;
    r.key     = key;
    r.pid     = PID_W'($urandom);
    r.name_lo = {$urandom, $urandom};
    r.name_hi = {$urandom, $urandom};
    return r;
  endfunction

  function automatic sock_req_t random_request();
    sock_req_t r;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)       cmd = CMD_CLEAR;
    else if (pick < 5)  cmd = CMD_RESERVED;
    else if (pick < 55) cmd = CMD_INSERT;
    else                cmd = CMD_LOOKUP;
    // mostly reuse recent keys so lookups and duplicate inserts hit
    pick = $urandom_range(0, 19);
    if (pick < 12 && recent_keys.size() != 0)
      key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else if (pick == 12) key = '0;
    else if (pick == 13) key = '1;
    else key = $urandom;
    r = make_request(cmd, key);
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.pid = '0;
    else if (pick == 1) r.pid = '1;
    else if (pick == 2) r.pid = 23'h400000;
    if (cmd == CMD_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
    end
    return r;
  endfunction

  function automatic bit table_busy();
    return sock_req_q.size() != 0 || in_tvalid || owner_reply_q.size() != 0;
  endfunction

  // sample on the falling edge so the driver's pop and valid update have landed
  task automatic settle();
    while (table_busy()) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_hash_shift(input logic [SHIFT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    shift_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_owner_reply(sending);
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (sock_req_q.size() != 0) begin
          sending = sock_req_q.pop_front();
          in_tuser  <= sending.cmd;
          in_tdata  <= IN_DATA_W'({sending.name_hi, sending.name_lo, sending.pid, sending.key});
          in_tvalid <= 1'b1;
          send_gap  <= draw_wait(send_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_reply();
    owner_reply_t want;
    owner_reply_t got;
    if (owner_reply_q.size() == 0) begin
      flag_error("reply with no request pending");
      return;
    end
    want = owner_reply_q.pop_front();
    got.found   = out_tuser[0];
    got.status  = out_tuser[1];
    got.pid     = out_tdata[PID_W-1:0];
    got.name_lo = out_tdata[PID_W +: NAME_W];
    got.name_hi = out_tdata[PID_W + NAME_W +: NAME_W];
    got.count   = out_tdata[PID_W + 2*NAME_W +: COUNT_W];
    if (got.found !== want.found)
      flag_error($sformatf("found %b, want %b", got.found, want.found));
    if (got.pid !== want.pid)
      flag_error($sformatf("owner_pid %h, want %h", got.pid, want.pid));
    if (got.name_lo !== want.name_lo)
      flag_error($sformatf("name_low %h, want %h", got.name_lo, want.name_lo));
    if (got.name_hi !== want.name_hi)
      flag_error($sformatf("name_high %h, want %h", got.name_hi, want.name_hi));
    if (got.status !== want.status)
      flag_error($sformatf("status %b, want %b", got.status, want.status));
    if (got.count !== want.count)
      flag_error($sformatf("entry_count %0d, want %0d", got.count, want.count));
  endtask

  // Reply monitor with random backpressure
  always @(posedge clk) begin
    int hold_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_hold  <= 0;
    end else if (out_tvalid && out_tready) begin
      check_reply();
      hold_next = draw_wait(recv_steady);
      recv_hold  <= hold_next;
      out_tready <= (hold_next == 0);
    end else if (recv_hold != 0) begin
      recv_hold  <= recv_hold - 1;
      out_tready <= (recv_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    sock_req_t r;
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k1;
    logic [SHIFT_W-1:0] shifts [8];
    int n;

    shifts = '{4'd1, 4'd10, 4'd5, 4'd0, 4'd15, 4'd2, 4'd8, 4'd10};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_hash_shift(4'd10);

    // key zero and all-ones keys, field extremes, unused command, clear
    sock_req_q.push_back(make_request(CMD_LOOKUP, '0));
    r = make_request(CMD_INSERT, '0);
    r.pid = '1; r.name_lo = '1; r.name_hi = '1;
    sock_req_q.push_back(r);
    r = make_request(CMD_INSERT, '0);
    r.pid = '0; r.name_lo = '0; r.name_hi = '0;
    sock_req_q.push_back(r);   // key zero never matches, so this appends again
    sock_req_q.push_back(make_request(CMD_LOOKUP, '0));
    r = make_request(CMD_INSERT, '1);
    r.pid = '0; r.name_lo = '0; r.name_hi = '0;
    sock_req_q.push_back(r);
    sock_req_q.push_back(make_request(CMD_LOOKUP, '1));
    sock_req_q.push_back(make_request(CMD_INSERT, '1));
    r = make_request(CMD_INSERT, 32'd1);
    r.pid = 23'h400000; r.name_lo = 64'h0123456789abcdef; r.name_hi = 64'hfedcba9876543210;
    sock_req_q.push_back(r);
    sock_req_q.push_back(make_request(CMD_LOOKUP, 32'd1));
    sock_req_q.push_back(make_request(CMD_RESERVED, $urandom));
    sock_req_q.push_back(make_request(CMD_CLEAR, $urandom));
    sock_req_q.push_back(make_request(CMD_LOOKUP, 32'd1));
    settle();

    // zero shift: one long chain in bucket 0
    set_hash_shift(4'd0);
    k0 = $urandom;
    k1 = k0 ^ 32'h8000_0001;
    sock_req_q.push_back(make_request(CMD_INSERT, k0));
    sock_req_q.push_back(make_request(CMD_INSERT, k1));
    sock_req_q.push_back(make_request(CMD_INSERT, ~k0));
    sock_req_q.push_back(make_request(CMD_LOOKUP, ~k0));
    sock_req_q.push_back(make_request(CMD_LOOKUP, k1));
    sock_req_q.push_back(make_request(CMD_INSERT, k1));
    settle();

    // shift wider than the bucket index, then narrowed without rehash
    set_hash_shift(4'd15);
    sock_req_q.push_back(make_request(CMD_INSERT, k0 + 32'd7));
    sock_req_q.push_back(make_request(CMD_INSERT, k1 - 32'd7));
    settle();
    set_hash_shift(4'd3);
    sock_req_q.push_back(make_request(CMD_LOOKUP, k0 + 32'd7));
    sock_req_q.push_back(make_request(CMD_LOOKUP, k1 - 32'd7));
    sock_req_q.push_back(make_request(CMD_LOOKUP, k0));
    settle();

    // fill the pool past its end
    set_hash_shift(4'd10);
    sock_req_q.push_back(make_request(CMD_CLEAR, '0));
    k0 = $urandom;
    sock_req_q.push_back(make_request(CMD_INSERT, k0));
    for (n = 0; n < ENTRIES_DEF + 8; n++)
      sock_req_q.push_back(make_request(CMD_INSERT, $urandom));
    sock_req_q.push_back(make_request(CMD_INSERT, '0));
    sock_req_q.push_back(make_request(CMD_INSERT, k0));
    sock_req_q.push_back(make_request(CMD_LOOKUP, k0));
    for (n = 0; n < 8; n++)
      sock_req_q.push_back(make_request(CMD_LOOKUP, $urandom));
    sock_req_q.push_back(make_request(CMD_CLEAR, '0));
    settle();

    // random traffic over a range of shifts; the bench adds no clear of its own in between
    foreach (shifts[p]) begin
      set_hash_shift(shifts[p]);
      for (n = 0; n < 66; n++) sock_req_q.push_back(random_request());
      settle();
    end

    repeat (32) @(posedge clk);
    if (owner_reply_q.size() != 0)
      flag_error($sformatf("%0d replies never arrived", owner_reply_q.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/somhm_pkg.sv
src/somhm_hash.sv
src/socket_owner_hash_map.sv
tb/socket_owner_hash_map_test.sv
